### hdl/positional_insert_delete_list_assert.svh
// Assertion shorthands shared by the list controller.
// The including module must provide aclk and aresetn.
`ifndef POSITIONAL_INSERT_DELETE_LIST_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_LIST_ASSERT_SVH

// Same-cycle implication.
`define PIDL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PIDL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/pidl_pkg.sv
`timescale 1ns / 1ps

package pidl_pkg;

    localparam int PIDL_DEPTH = 64;
    localparam int VALUE_W    = 32;
    localparam int POS_W      = 7;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE  = 3'd0,
        OP_LOAD    = 3'd1,
        OP_INSERT  = 3'd2,
        OP_DELETE  = 3'd3,
        OP_DISPLAY = 3'd4
    } op_e_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_FULL        = 3'd1,
        ST_EMPTY       = 3'd2,
        ST_BAD_POS     = 3'd3,
        ST_BAD_COUNT   = 3'd4,
        ST_NOT_LOADING = 3'd5
    } status_e_t;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_DISP = 1'b1
    } state_e_t;

    // Controller to datapath.
    typedef struct packed {
        logic exec;        // input transfer this cycle
        logic out_single;  // load a single-result item into the output register
        logic disp_step;   // emit one display entry and rotate the list
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic list_empty;
        logic disp_last;
    } stat_t;

endpackage

### hdl/pidl_ctrl.sv
`timescale 1ns / 1ps
`include "positional_insert_delete_list_assert.svh"

module pidl_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  pidl_pkg::op_e_t op,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  pidl_pkg::stat_t stat,
    output pidl_pkg::cmd_t  cmd
);
    import pidl_pkg::*;

    state_e_t state_reg, state_next;
    logic     m_valid_reg, m_valid_next;
    logic     out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        s_tready       = 1'b0;
        cmd.exec       = 1'b0;
        cmd.out_single = 1'b0;
        cmd.disp_step  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = out_free;
                cmd.exec = s_tvalid && out_free;
                if (cmd.exec) begin
                    case (op)
                        OP_CREATE, OP_LOAD, OP_INSERT, OP_DELETE: begin
                            cmd.out_single = 1'b1;
                            m_valid_next   = 1'b1;
                        end
                        OP_DISPLAY: begin
                            if (stat.list_empty) begin
                                cmd.out_single = 1'b1;
                                m_valid_next   = 1'b1;
                            end else begin
                                state_next = S_DISP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DISP: begin
                if (out_free) begin
                    cmd.disp_step = 1'b1;
                    m_valid_next  = 1'b1;
                    if (stat.disp_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    `PIDL_ASSERT_NXT(a_disp_holds_on_stall, (state_reg == S_DISP) && m_valid_reg && !m_tready,
                     state_reg == S_DISP, "display left while an entry was stalled")
    `PIDL_ASSERT_NXT(a_disp_start, cmd.exec && (op == OP_DISPLAY) && !stat.list_empty,
                     (state_reg == S_DISP) && !m_valid_reg, "display did not start cleanly")
    `PIDL_ASSERT_NXT(a_disp_end, cmd.disp_step && stat.disp_last,
                     (state_reg == S_IDLE) && m_valid_reg, "final display entry not presented")

endmodule

### hdl/pidl_datapath.sv
`timescale 1ns / 1ps

module pidl_datapath #(
    parameter int DEPTH = pidl_pkg::PIDL_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pidl_pkg::cmd_t                cmd,
    input  pidl_pkg::op_e_t               op,
    input  logic [pidl_pkg::VALUE_W-1:0]  value,
    input  logic [pidl_pkg::POS_W-1:0]    position,
    output pidl_pkg::stat_t               stat,
    output logic [pidl_pkg::STATUS_W-1:0] out_status,
    output logic [pidl_pkg::VALUE_W-1:0]  out_data,
    output logic                          out_last
);
    import pidl_pkg::*;

    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = POS_W + 1;
    localparam logic [CW-1:0] DEPTH_X = CW'(DEPTH);

    logic [VALUE_W-1:0] cell_reg [DEPTH];
    logic [VALUE_W-1:0] cell_next [DEPTH];
    logic [LW-1:0]      len_reg, len_next;
    logic [LW-1:0]      loads_reg, loads_next;
    logic [LW-1:0]      cnt_reg, cnt_next;
    status_e_t          status_reg, status_next;
    logic [VALUE_W-1:0] data_reg, data_next;
    logic               last_reg, last_next;

    logic [CW-1:0] pos_x, pos_m1, len_x, len_m1;
    logic          full, count_ok, load_ok, ins_ok, del_ok;
    status_e_t     single_status;

    assign pos_x  = {1'b0, position};
    assign pos_m1 = pos_x - CW'(1);
    assign len_x  = CW'(len_reg);
    assign len_m1 = len_x - CW'(1);

    assign full     = len_x >= DEPTH_X;
    assign count_ok = (pos_x != '0) && (pos_x <= DEPTH_X);
    assign load_ok  = (loads_reg != '0) && !full;
    assign ins_ok   = !full && (pos_x != '0) && (pos_x <= len_x + CW'(1));
    assign del_ok   = (len_reg != '0) && (pos_x != '0) && (pos_x <= len_x);

    assign stat.list_empty = (len_reg == '0);
    assign stat.disp_last  = (cnt_reg == len_reg - LW'(1));

    always_comb begin
        case (op)
            OP_CREATE:  single_status = count_ok ? ST_OK : ST_BAD_COUNT;
            OP_LOAD:    single_status = load_ok ? ST_OK : ST_NOT_LOADING;
            OP_INSERT:  single_status = full ? ST_FULL : (ins_ok ? ST_OK : ST_BAD_POS);
            OP_DELETE:  single_status = (len_reg == '0) ? ST_EMPTY :
                                        (del_ok ? ST_OK : ST_BAD_POS);
            OP_DISPLAY: single_status = ST_EMPTY;
            default:    single_status = ST_OK;
        endcase
    end

    // Each cell only looks at its own neighbors, cell 0, the input value and the bookkeeping.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_next[i] = cell_reg[i];
            if (cmd.exec) begin
                case (op)
                    OP_LOAD: begin
                        if (load_ok && (CW'(i) == len_x)) cell_next[i] = value;
                    end
                    OP_INSERT: begin
                        if (ins_ok) begin
                            if (CW'(i) == pos_m1) begin
                                cell_next[i] = value;
                            end else if ((i > 0) && (CW'(i) > pos_m1)) begin
                                cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
                            end
                        end
                    end
                    OP_DELETE: begin
                        if (del_ok && (i < DEPTH - 1) && (CW'(i) >= pos_m1)) begin
                            cell_next[i] = cell_reg[(i < DEPTH - 1) ? i + 1 : i];
                        end
                    end
                    default: ;
                endcase
            end else if (cmd.disp_step) begin
                if (CW'(i) == len_m1) begin
                    cell_next[i] = cell_reg[0];
                end else if ((i < DEPTH - 1) && (CW'(i) < len_m1)) begin
                    cell_next[i] = cell_reg[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_comb begin
        len_next    = len_reg;
        loads_next  = loads_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        data_next   = data_reg;
        last_next   = last_reg;
        if (cmd.exec) begin
            case (op)
                OP_CREATE: begin
                    len_next   = '0;
                    loads_next = count_ok ? position[LW-1:0] : '0;
                end
                OP_LOAD: begin
                    if (load_ok) begin
                        len_next   = len_reg + LW'(1);
                        loads_next = loads_reg - LW'(1);
                    end
                end
                OP_INSERT: begin
                    loads_next = '0;
                    if (ins_ok) len_next = len_reg + LW'(1);
                end
                OP_DELETE: begin
                    loads_next = '0;
                    if (del_ok) len_next = len_reg - LW'(1);
                end
                OP_DISPLAY: begin
                    loads_next = '0;
                    cnt_next   = '0;
                end
                default: ;
            endcase
        end
        if (cmd.out_single) begin
            status_next = single_status;
            data_next   = '0;
            last_next   = 1'b1;
        end else if (cmd.disp_step) begin
            status_next = ST_OK;
            data_next   = cell_reg[0];
            last_next   = stat.disp_last;
            cnt_next    = cnt_reg + LW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            loads_reg <= '0;
            cnt_reg   <= '0;
        end else begin
            len_reg   <= len_next;
            loads_reg <= loads_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_reg[i] <= cell_next[i];
        end
        status_reg <= status_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
    end

    assign out_status = status_reg;
    assign out_data   = data_reg;
    assign out_last   = last_reg;

endmodule

### hdl/positional_insert_delete_list.sv
`timescale 1ns / 1ps
// Channel   Direction  Ports                           Contents
// s_        in         s_tvalid s_tready s_tdata s_tuser  one operation
// m_        out        m_tvalid m_tready m_tdata m_tuser m_tlast  one result
//
// Create, load, insert and delete give one result each; an unknown op is
// taken with none. Cells shift in place, so insert and delete finish as
// the result is registered. Display gives one empty status on an empty
// list, else emits the entries as the output register drains, rotating
// the list through cell 0 once, back to its order. Reset clears length,
// load count and handshake state; cells hold anything. A stalled result
// holds the output register; a new operation is taken in the cycle it drains.

module positional_insert_delete_list #(
    parameter int DEPTH = pidl_pkg::PIDL_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] value, [38:32] position, [39] unused
    input  logic [2:0]  s_tuser,   // [2:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] data
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast
);
    import pidl_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    op_e_t op;

    // Decode the operation code carried beside the data.
    assign op = op_e_t'(s_tuser);

    pidl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (op),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the list cells, length, load count and the result register.
    pidl_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .op         (op),
        .value      (s_tdata[VALUE_W-1:0]),
        .position   (s_tdata[VALUE_W+POS_W-1:VALUE_W]),
        .stat       (stat),
        .out_status (m_tuser),
        .out_data   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule
